/* sv/lsw_pkg.sv */
`default_nettype none
package lsw_pkg;

	localparam int COORD_BITS  = 10;
	localparam int FRAC_BITS   = 6;
	localparam int OUT_BITS    = 16;
	localparam int QUOT_BITS   = COORD_BITS + FRAC_BITS;
	localparam int NUM_BITS    = 2 * COORD_BITS + FRAC_BITS + 1;
	localparam int REM_BITS    = COORD_BITS + 2;
	localparam int PROD_BITS   = 2 * COORD_BITS + 2;
	localparam int BACK_STAGES = QUOT_BITS + 6;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = 2;

	typedef logic [COORD_BITS-1:0]        coord_t;
	typedef logic signed [COORD_BITS:0]   scoord_t;
	typedef logic [COORD_BITS:0]          den_t;

	typedef enum logic [1:0] {
		CFG_LEFT   = 2'd0,
		CFG_BOTTOM = 2'd1,
		CFG_RIGHT  = 2'd2,
		CFG_TOP    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BND_SKIP,
		BND_ENTRY,
		BND_EXIT
	} bnd_kind_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} seg_in_t;

	typedef struct packed {
		logic                visible;
		logic [OUT_BITS-1:0] clip_start_x;
		logic [OUT_BITS-1:0] clip_start_y;
		logic [OUT_BITS-1:0] clip_end_x;
		logic [OUT_BITS-1:0] clip_end_y;
	} seg_out_t;

	// Classified segment: each boundary reduced to a skip, or an entry or exit fraction rn/rd.
	typedef struct packed {
		logic                  accept;
		coord_t                sx;
		coord_t                sy;
		scoord_t               dx;
		scoord_t               dy;
		bnd_kind_t [3:0]       kind;
		scoord_t [3:0]         rn;
		coord_t [3:0]          rd;
	} cls_t;

	typedef struct packed {
		scoord_t n1;
		coord_t  d1;
		scoord_t n2;
		coord_t  d2;
	} frac_t;

	typedef struct packed {
		cls_t  c;
		frac_t f;
	} nar_t;

	typedef struct packed {
		logic [REM_BITS-1:0]  rem;
		logic [QUOT_BITS-1:0] lo;
	} div_lane_t;

	typedef struct packed {
		logic                  vis;
		den_t                  den1;
		den_t                  den2;
		div_lane_t [3:0]       lane;
	} div_t;

	function automatic logic signed [PROD_BITS-1:0] smul(input scoord_t a, input coord_t b);
		logic signed [PROD_BITS-1:0] ea;
		logic signed [PROD_BITS-1:0] eb;
		ea = PROD_BITS'(a);
		eb = PROD_BITS'($signed({1'b0, b}));
		return ea * eb;
	endfunction

endpackage
`default_nettype wire

/* sv/lsw_front.sv */
`default_nettype none
module lsw_front import lsw_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [COORD_BITS-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire seg_in_t               in_data,
	output logic                       cls_valid,
	input  wire logic                  cls_ready,
	output cls_t                       cls_data
);

	typedef struct packed {
		bnd_kind_t kind;
		scoord_t   rn;
		coord_t    rd;
		logic      rej;
	} bnd_t;

	coord_t win_left_q, win_bottom_q, win_right_q, win_top_q;
	logic   vld_s1;
	cls_t   cls_s1;
	cls_t   cls_nxt;

	function automatic scoord_t sdiff(input coord_t a, input coord_t b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	function automatic bnd_t classify(input scoord_t p, input scoord_t q);
		bnd_t r;
		r.kind = BND_SKIP;
		r.rn   = q;
		r.rd   = '0;
		r.rej  = 1'b0;
		if (p == '0) begin
			r.rej = q < 0;
		end else if (p < 0) begin
			r.kind = BND_ENTRY;
			r.rn   = -q;
			r.rd   = COORD_BITS'(-p);
		end else begin
			r.kind = BND_EXIT;
			r.rn   = q;
			r.rd   = COORD_BITS'(p);
		end
		return r;
	endfunction

	always_comb begin
		bnd_t    b [4];
		scoord_t dx, dy;
		dx = sdiff(in_data.end_x, in_data.start_x);
		dy = sdiff(in_data.end_y, in_data.start_y);
		b[0] = classify(-dx, sdiff(in_data.start_x, win_left_q));
		b[1] = classify(dx, sdiff(win_right_q, in_data.start_x));
		b[2] = classify(-dy, sdiff(in_data.start_y, win_bottom_q));
		b[3] = classify(dy, sdiff(win_top_q, in_data.start_y));
		cls_nxt.accept = !(b[0].rej || b[1].rej || b[2].rej || b[3].rej);
		cls_nxt.sx = in_data.start_x;
		cls_nxt.sy = in_data.start_y;
		cls_nxt.dx = dx;
		cls_nxt.dy = dy;
		for (int i = 0; i < 4; i++) begin
			cls_nxt.kind[i] = b[i].kind;
			cls_nxt.rn[i]   = b[i].rn;
			cls_nxt.rd[i]   = b[i].rd;
		end
	end

	assign in_ready  = !vld_s1 || cls_ready;
	assign cls_valid = vld_s1;
	assign cls_data  = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= '0;
			win_bottom_q <= '0;
			win_right_q  <= '1;
			win_top_q    <= '1;
			vld_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_LEFT:   win_left_q   <= cfg_data;
					CFG_BOTTOM: win_bottom_q <= cfg_data;
					CFG_RIGHT:  win_right_q  <= cfg_data;
					CFG_TOP:    win_top_q    <= cfg_data;
					default: ;
				endcase
			end
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cls_s1 <= cls_nxt;
		end
	end

endmodule
`default_nettype wire

/* sv/lsw_fifo.sv */
`default_nettype none
module lsw_fifo import lsw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cls_t push_data,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cls_t      pop_data
);

	cls_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push, pop;

	assign push_ready = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

/* sv/lsw_back.sv */
`default_nettype none
module lsw_back import lsw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cls_valid,
	output logic      cls_ready,
	input  wire cls_t cls_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output seg_out_t  out_data
);

	logic [BACK_STAGES-1:0] vld_q;
	logic                   adv;

	nar_t nar_s [4];
	nar_t nar_nxt [4];
	nar_t vis_s5;
	logic vis_flag_s5;
	div_t num_s6;
	div_t num_nxt;
	div_t div_s [QUOT_BITS];
	div_t div_nxt [QUOT_BITS];
	logic vis_nxt;

	// One boundary of the entry/exit narrowing, compared by cross multiplication.
	function automatic nar_t narrow(input nar_t a, input logic [1:0] b);
		nar_t r;
		r = a;
		case (a.c.kind[b])
			BND_ENTRY: begin
				if (smul(a.c.rn[b], a.f.d1) > smul(a.f.n1, a.c.rd[b])) begin
					r.f.n1 = a.c.rn[b];
					r.f.d1 = a.c.rd[b];
				end
			end
			BND_EXIT: begin
				if (smul(a.c.rn[b], a.f.d2) < smul(a.f.n2, a.c.rd[b])) begin
					r.f.n2 = a.c.rn[b];
					r.f.d2 = a.c.rd[b];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// (s*d + n*delta) * 2^(F+1) + d, the numerator of the rounded quotient over 2d.
	function automatic logic [NUM_BITS-1:0] cnum(input coord_t s, input scoord_t delta,
			input scoord_t n, input coord_t d);
		logic signed [PROD_BITS:0] a;
		logic signed [PROD_BITS:0] b;
		logic signed [PROD_BITS:0] x;
		a = (PROD_BITS+1)'($signed({1'b0, s})) * (PROD_BITS+1)'($signed({1'b0, d}));
		b = (PROD_BITS+1)'(n) * (PROD_BITS+1)'(delta);
		x = a + b;
		return NUM_BITS'({x[2*COORD_BITS-1:0], (FRAC_BITS+1)'(0)}) + NUM_BITS'(d);
	endfunction

	function automatic div_lane_t dstep(input div_lane_t a, input den_t den);
		div_lane_t            r;
		logic [REM_BITS-1:0]  t;
		logic                 qb;
		t  = {a.rem[REM_BITS-2:0], a.lo[QUOT_BITS-1]};
		qb = t >= REM_BITS'(den);
		r.rem = qb ? t - REM_BITS'(den) : t;
		r.lo  = {a.lo[QUOT_BITS-2:0], qb};
		return r;
	endfunction

	assign adv       = !vld_q[BACK_STAGES-1] || out_ready;
	assign cls_ready = adv;

	always_comb begin
		nar_t init;
		init.c    = cls_data;
		init.f.n1 = '0;
		init.f.d1 = COORD_BITS'(1);
		init.f.n2 = (COORD_BITS+1)'(1);
		init.f.d2 = COORD_BITS'(1);
		for (int k = 0; k < 4; k++) begin
			nar_nxt[k] = narrow((k == 0) ? init : nar_s[(k == 0) ? 0 : k-1], 2'(k));
		end
		vis_nxt = nar_s[3].c.accept &&
			(smul(nar_s[3].f.n1, nar_s[3].f.d2) < smul(nar_s[3].f.n2, nar_s[3].f.d1));
	end

	always_comb begin
		logic [NUM_BITS-1:0] nm [4];
		nm[0] = cnum(vis_s5.c.sx, vis_s5.c.dx, vis_s5.f.n1, vis_s5.f.d1);
		nm[1] = cnum(vis_s5.c.sy, vis_s5.c.dy, vis_s5.f.n1, vis_s5.f.d1);
		nm[2] = cnum(vis_s5.c.sx, vis_s5.c.dx, vis_s5.f.n2, vis_s5.f.d2);
		nm[3] = cnum(vis_s5.c.sy, vis_s5.c.dy, vis_s5.f.n2, vis_s5.f.d2);
		num_nxt.vis  = vis_flag_s5;
		num_nxt.den1 = {vis_s5.f.d1, 1'b0};
		num_nxt.den2 = {vis_s5.f.d2, 1'b0};
		for (int i = 0; i < 4; i++) begin
			// A hidden segment divides zero, so its coordinates come out as zero.
			if (!vis_flag_s5) begin
				nm[i] = '0;
			end
			num_nxt.lane[i].rem = REM_BITS'(nm[i][NUM_BITS-1:QUOT_BITS]);
			num_nxt.lane[i].lo  = nm[i][QUOT_BITS-1:0];
		end
	end

	always_comb begin
		div_t src;
		for (int j = 0; j < QUOT_BITS; j++) begin
			src = (j == 0) ? num_s6 : div_s[(j == 0) ? 0 : j-1];
			div_nxt[j] = src;
			div_nxt[j].lane[0] = dstep(src.lane[0], src.den1);
			div_nxt[j].lane[1] = dstep(src.lane[1], src.den1);
			div_nxt[j].lane[2] = dstep(src.lane[2], src.den2);
			div_nxt[j].lane[3] = dstep(src.lane[3], src.den2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[BACK_STAGES-2:0], cls_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				nar_s[k] <= nar_nxt[k];
			end
			vis_s5      <= nar_s[3];
			vis_flag_s5 <= vis_nxt;
			num_s6      <= num_nxt;
			for (int j = 0; j < QUOT_BITS; j++) begin
				div_s[j] <= div_nxt[j];
			end
		end
	end

	assign out_valid             = vld_q[BACK_STAGES-1];
	assign out_data.visible      = div_s[QUOT_BITS-1].vis;
	assign out_data.clip_start_x = OUT_BITS'(div_s[QUOT_BITS-1].lane[0].lo);
	assign out_data.clip_start_y = OUT_BITS'(div_s[QUOT_BITS-1].lane[1].lo);
	assign out_data.clip_end_x   = OUT_BITS'(div_s[QUOT_BITS-1].lane[2].lo);
	assign out_data.clip_end_y   = OUT_BITS'(div_s[QUOT_BITS-1].lane[3].lo);

endmodule
`default_nettype wire

/* sv/line_segment_window_clipper_top.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data   (seg_in_t)
// out       output     out_valid / out_ready  out_data  (seg_out_t)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// One segment per cycle is accepted and one result per cycle is delivered while the
// output is not stalled. A segment passes the classify register, the four-entry queue
// and the 22 back-end stages (four narrowing steps, the visibility compare, the
// numerator products and a 16-step restoring divider).
// Reset clears valid state and loads the full 0..1023 window.
// A stalled output freezes the back end only; the queue and the front keep
// taking requests until the queue fills.
`default_nettype none
module line_segment_window_clipper_top import lsw_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [COORD_BITS-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire seg_in_t               in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output seg_out_t                   out_data
);

	logic cf_valid, cf_ready, fb_valid, fb_ready;
	cls_t cf_data, fb_data;

	lsw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cls_valid (cf_valid),
		.cls_ready (cf_ready),
		.cls_data  (cf_data)
	);

	lsw_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cf_valid),
		.push_ready (cf_ready),
		.push_data  (cf_data),
		.pop_valid  (fb_valid),
		.pop_ready  (fb_ready),
		.pop_data   (fb_data)
	);

	lsw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (fb_valid),
		.cls_ready (fb_ready),
		.cls_data  (fb_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

/* sv/lsw_checker.sv */
`default_nettype none
module lsw_checker import lsw_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire seg_in_t               in_data,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire seg_out_t              out_data
);

	localparam logic [OUT_BITS-1:0] MAX_COORD = OUT_BITS'(((1 << COORD_BITS) - 1) << FRAC_BITS);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.visible |->
			out_data.clip_start_x == '0 && out_data.clip_start_y == '0 &&
			out_data.clip_end_x == '0 && out_data.clip_end_y == '0)
		else $error("hidden segment carries nonzero coordinates");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.visible |->
			out_data.clip_start_x <= MAX_COORD && out_data.clip_start_y <= MAX_COORD &&
			out_data.clip_end_x <= MAX_COORD && out_data.clip_end_y <= MAX_COORD)
		else $error("clipped coordinate beyond the coordinate range");

endmodule

bind line_segment_window_clipper_top lsw_checker u_lsw_checker (.*);
`default_nettype wire

/* dv/clip_checker.sv */
`default_nettype none
module clip_checker import lsw_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [COORD_BITS-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire seg_in_t               in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire seg_out_t              out_data,
	output int                         fail_count,
	output int                         pending,
	output int                         visible_seen,
	output int                         result_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	longint win_left, win_bottom, win_right, win_top;
	seg_out_t clip_queue[$];

	// Nearest 1/64 pixel of s + (n/d)*delta, ties upward, clamped to the field.
	function automatic logic [OUT_BITS-1:0] fixed_point_at(longint s, longint delta,
			longint n, longint d);
		longint x, num, den, qv;
		x = s * d + n * delta;
		num = x * (longint'(2) << FRAC_BITS) + d;
		den = 2 * d;
		qv = num / den;
		if ((num % den) != 0 && num < 0) qv -= 1;
		if (qv < 0) qv = 0;
		if (qv > 65535) qv = 65535;
		return qv[OUT_BITS-1:0];
	endfunction

	function automatic seg_out_t clip_segment(seg_in_t seg);
		longint sx, sy, dx, dy, n1, d1, n2, d2, rn, rd;
		longint p[4], q[4];
		bit keep;
		seg_out_t r;
		sx = seg.start_x; sy = seg.start_y;
		dx = longint'(seg.end_x) - sx;
		dy = longint'(seg.end_y) - sy;
		n1 = 0; d1 = 1; n2 = 1; d2 = 1; keep = 1;
		p[0] = -dx; q[0] = sx - win_left;
		p[1] = dx;  q[1] = win_right - sx;
		p[2] = -dy; q[2] = sy - win_bottom;
		p[3] = dy;  q[3] = win_top - sy;
		for (int i = 0; i < 4; i++) begin
			if (p[i] == 0) begin
				if (q[i] < 0) begin
					keep = 0;
					break;
				end
			end else if (p[i] < 0) begin
				rn = -q[i]; rd = -p[i];
				if (rn * d1 > n1 * rd) begin n1 = rn; d1 = rd; end
			end else begin
				rn = q[i]; rd = p[i];
				if (rn * d2 < n2 * rd) begin n2 = rn; d2 = rd; end
			end
		end
		r = '0;
		if (keep && n1 * d2 < n2 * d1) begin
			r.visible = 1'b1;
			r.clip_start_x = fixed_point_at(sx, dx, n1, d1);
			r.clip_start_y = fixed_point_at(sy, dy, n1, d1);
			r.clip_end_x = fixed_point_at(sx, dx, n2, d2);
			r.clip_end_y = fixed_point_at(sy, dy, n2, d2);
		end
		return r;
	endfunction

	assign pending = clip_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left <= 0; win_bottom <= 0; win_right <= 1023; win_top <= 1023;
			fail_count <= 0; visible_seen <= 0; result_seen <= 0;
			clip_queue.delete();
		end else begin
			if (in_valid && in_ready) clip_queue.push_back(clip_segment(in_data));
			if (out_valid && out_ready) begin
				result_seen <= result_seen + 1;
				if (out_data.visible) visible_seen <= visible_seen + 1;
				if (clip_queue.size() == 0) begin
					if (fail_count < 10) $display("unexpected result %p", out_data);
					fail_count <= fail_count + 1;
				end else begin
					seg_out_t want;
					want = clip_queue.pop_front();
					if (want != out_data) begin
						if (fail_count < 10)
							$display("mismatch: expected %p, got %p", want, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_LEFT:   win_left <= cfg_data;
					CFG_BOTTOM: win_bottom <= cfg_data;
					CFG_RIGHT:  win_right <= cfg_data;
					CFG_TOP:    win_top <= cfg_data;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none
module tb_top import lsw_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n, cfg_we, in_valid, out_ready, in_ready, out_valid;
	logic [1:0] cfg_index;
	logic [COORD_BITS-1:0] cfg_data;
	seg_in_t in_data;
	seg_out_t out_data;
	int fail_count, pending, visible_seen, result_seen;
	int cycle_count;
	int segs_sent;

	line_segment_window_clipper_top u_top (.*);
	clip_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver stalls at random, with long stretches of always ready.
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (cycle_count % 1500 < 300) out_ready <= 1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic write_window(int left, int bottom, int right, int top);
		int vals[4];
		vals = '{left, bottom, right, top};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we <= 1; cfg_index <= 2'(i); cfg_data <= COORD_BITS'(vals[i]);
		end
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_segment(int sx, int sy, int ex, int ey);
		in_valid <= 1;
		in_data <= '{start_x: COORD_BITS'(sx), start_y: COORD_BITS'(sy),
			end_x: COORD_BITS'(ex), end_y: COORD_BITS'(ey)};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		segs_sent++;
	endtask

	task automatic idle_gap();
		in_valid <= 0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	function automatic int near_coord(int lo, int hi);
		int c;
		c = $urandom_range(0, 3) == 0 ? lo : hi;
		c += $urandom_range(0, 4) - 2;
		if (c < 0) c = 0;
		if (c > 1023) c = 1023;
		return c;
	endfunction

	task automatic random_phase(int count, int l, int b, int r, int t);
		int burst;
		burst = 0;
		repeat (count) begin
			int mode;
			if (burst == 0) begin
				idle_gap();
				burst = $urandom_range(1, 40);
			end
			burst--;
			mode = $urandom_range(0, 9);
			if (mode < 5)
				send_segment($urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 1023));
			else if (mode < 8)
				send_segment(near_coord(l, r), near_coord(b, t),
					near_coord(l, r), near_coord(b, t));
			else begin
				// Axis-parallel or degenerate segments.
				int a, c;
				a = $urandom_range(0, 1023); c = $urandom_range(0, 1023);
				if ($urandom_range(0, 1)) send_segment(a, c, $urandom_range(0, 1023), c);
				else send_segment(a, c, a, $urandom_range(0, 2) == 0 ? c :
					$urandom_range(0, 1023));
			end
		end
		in_valid <= 0;
	endtask

	initial begin
		int wl, wb, wr, wt;
		segs_sent = 0;
		arst_n = 0; cfg_we = 0; cfg_index = CFG_LEFT; cfg_data = '0;
		in_valid = 0; in_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed cases on the full reset window.
		send_segment(0, 0, 1023, 1023);
		send_segment(1023, 1023, 0, 0);
		send_segment(512, 512, 512, 512);
		send_segment(0, 1023, 1023, 0);
		send_segment(5, 7, 900, 7);
		send_segment(5, 7, 5, 900);
		in_valid <= 0;
		drain();
		write_window(100, 200, 300, 400);
		send_segment(0, 300, 1023, 300);
		send_segment(50, 50, 350, 450);
		send_segment(50, 300, 90, 300);
		send_segment(100, 200, 100, 200);
		send_segment(99, 200, 99, 200);
		send_segment(0, 100, 400, 500);
		send_segment(0, 200, 300, 500);
		send_segment(0, 0, 1023, 1023);
		send_segment(300, 400, 101, 201);
		send_segment(1, 2, 1022, 1021);
		send_segment(150, 500, 150, 100);
		in_valid <= 0;
		drain();
		write_window(600, 600, 400, 400);
		send_segment(500, 500, 500, 500);
		send_segment(0, 0, 1023, 1023);
		in_valid <= 0;
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin wl = 0; wb = 0; wr = 1023; wt = 1023; end
				1: begin wl = 1023; wb = 1023; wr = 1023; wt = 1023; end
				2: begin wl = 0; wb = 0; wr = 0; wt = 0; end
				3: begin wl = 700; wb = 300; wr = 200; wt = 800; end
				default: begin
					wl = $urandom_range(0, 900); wb = $urandom_range(0, 900);
					wr = $urandom_range(wl, 1023); wt = $urandom_range(wb, 1023);
				end
			endcase
			write_window(wl, wb, wr, wt);
			random_phase(ph < 4 ? 120 : 300, wl, wb, wr, wt);
			drain();
		end

		$display("Sent %0d segments over eleven windows, including one-pixel and inverted ones.",
			segs_sent);
		$display("Checked %0d results, %0d of them visible.", result_seen, visible_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire
